FILE: src/assert_macros.svh
// Assertion macros shared by the labeler RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GOAL_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("labeler check failed");

// Next-cycle implication, disabled during reset.
`define GOAL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("labeler check failed");

`endif

FILE: src/goal_pkg.sv
// Shared types and constants for the grid object area labeler.
// No dependencies; imported by every module of the block.
package goal_pkg;

  localparam int DEF_MAX_ROWS = 32;
  localparam int DEF_MAX_COLS = 32;

  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_W     = 10;
  localparam int AREA_W    = 11;
  localparam int CHAR_W    = 8;

  localparam logic [CFG_W-1:0]  CFG_ROWS_RESET = 6'd32;
  localparam logic [CFG_W-1:0]  CFG_COLS_RESET = 6'd32;
  localparam logic [CHAR_W-1:0] EMPTY_CHAR     = 8'd48;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_FIND = 1'b1;

  // bit positions in a cell memory entry
  localparam int CELL_OBJ = 1;
  localparam int CELL_VIS = 0;

  // neighbor slots walked per popped cell
  localparam logic [2:0] NB_RIGHT = 3'd0;
  localparam logic [2:0] NB_LEFT  = 3'd1;
  localparam logic [2:0] NB_DOWN  = 3'd2;
  localparam logic [2:0] NB_UP    = 3'd3;
  localparam logic [2:0] NB_LAST  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_POP,
    ST_POP_WAIT,
    ST_NBR
  } state_t;

endpackage

FILE: src/grid_object_area_labeler.sv
// Top level of the grid object area labeler: flood fill over 4-connected cells.
// Depends on goal_pkg, goal_ram, goal_mod_unit and assert_macros.svh.
//
//   channel   handshake                  payload
//   command   start / busy               cmd, cell_char
//   result    done (one-cycle strobe)    object_number, object_area, none_left
//   config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
// Load: busy stays low. Find: derive the scan column with the remainder unit, then
// read and check each scanned cell; per object cell pop, wait for the read, make four
// neighbor probes on the one cell memory read port and a last check; finally see the
// stack empty or the scan ended. The result strobe comes in the same cycle that busy
// drops and cannot be stalled; config writes wait while busy. Reset clears control
// state only: no clearing pass, since a load rewrites each cell's visited bit.
`include "assert_macros.svh"

module grid_object_area_labeler
  import goal_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 cmd,
  input  logic [CHAR_W-1:0]    cell_char,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 done,
  output logic [NUM_W-1:0]     object_number,
  output logic [AREA_W-1:0]    object_area,
  output logic                 none_left
);

  localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
  localparam int IW = $clog2(CELL_COUNT);
  localparam int PW = $clog2(CELL_COUNT + 1);
  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int SW = IW + CW;

  logic [CFG_W-1:0] grid_rows, grid_cols;
  logic [RW-1:0]    rows_used;
  logic [CW-1:0]    cols_used;
  logic [PW-1:0]    total;

  state_t state, state_next;

  logic [PW-1:0]     load_pos, scan_pos, depth, depth_dec;
  logic [CW-1:0]     scan_col, scan_col_inc;
  logic [IW-1:0]     scan_idx, cur_idx, chk_addr, n_addr;
  logic [CW-1:0]     scan_idx_col, cur_col, chk_col, n_col;
  logic [2:0]        nb;
  logic              chk_ok, n_ok;
  logic [AREA_W-1:0] area;
  logic [NUM_W-1:0]  found;

  logic          cell_we, cell_re;
  logic [IW-1:0] cell_waddr, cell_raddr;
  logic [1:0]    cell_wdata, cell_rdata;
  logic          stk_we, stk_re;
  logic [IW-1:0] stk_waddr, stk_raddr;
  logic [SW-1:0] stk_wdata, stk_rdata;
  logic          mod_start, mod_done;
  logic [CW-1:0] mod_rem;

  logic accept, find_go, load_go, hit, scan_end, report_obj, report_none;

  // out-of-range register values act as the nearest legal size
  always_comb begin
    if (grid_rows == '0) begin
      rows_used = RW'(1);
    end else if (32'(grid_rows) > MAX_ROWS) begin
      rows_used = RW'(MAX_ROWS);
    end else begin
      rows_used = RW'(grid_rows);
    end
    if (grid_cols == '0) begin
      cols_used = CW'(1);
    end else if (32'(grid_cols) > MAX_COLS) begin
      cols_used = CW'(MAX_COLS);
    end else begin
      cols_used = CW'(grid_cols);
    end
  end

  assign total = PW'(rows_used) * PW'(cols_used);

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign find_go   = accept && (cmd == CMD_FIND);
  assign load_go   = accept && (cmd == CMD_LOAD) && (load_pos < total);
  assign hit       = cell_rdata[CELL_OBJ] && !cell_rdata[CELL_VIS];
  assign scan_end  = (scan_pos >= total);
  assign depth_dec = depth - PW'(1);

  assign report_none = (state == ST_SCAN_RD) && scan_end;
  assign report_obj  = (state == ST_POP) && (depth == '0);

  assign scan_col_inc = ((CW + 1)'(scan_col) + (CW + 1)'(1) == (CW + 1)'(cols_used)) ?
                        '0 : scan_col + CW'(1);

  // neighbor probed in the current slot
  always_comb begin
    n_ok   = 1'b0;
    n_addr = cur_idx;
    n_col  = cur_col;
    case (nb)
      NB_RIGHT: begin
        n_ok   = ((CW + 1)'(cur_col) + (CW + 1)'(1) < (CW + 1)'(cols_used)) &&
                 ((PW + 1)'(cur_idx) + (PW + 1)'(1) < (PW + 1)'(total));
        n_addr = cur_idx + IW'(1);
        n_col  = cur_col + CW'(1);
      end
      NB_LEFT: begin
        n_ok   = (cur_col != '0);
        n_addr = cur_idx - IW'(1);
        n_col  = cur_col - CW'(1);
      end
      NB_DOWN: begin
        n_ok   = ((PW + 1)'(cur_idx) + (PW + 1)'(cols_used) < (PW + 1)'(total));
        n_addr = cur_idx + IW'(cols_used);
      end
      NB_UP: begin
        n_ok   = (PW'(cur_idx) >= PW'(cols_used));
        n_addr = cur_idx - IW'(cols_used);
      end
      default: begin
        n_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (find_go) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (mod_done) begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        state_next = scan_end ? ST_IDLE : ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        state_next = hit ? ST_POP : ST_SCAN_RD;
      end
      ST_POP: begin
        state_next = (depth == '0) ? ST_IDLE : ST_POP_WAIT;
      end
      ST_POP_WAIT: begin
        state_next = ST_NBR;
      end
      ST_NBR: begin
        if (nb == NB_LAST) begin
          state_next = ST_POP;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = chk_addr;
    cell_wdata = 2'b11;
    cell_re    = 1'b0;
    cell_raddr = n_addr;
    stk_we     = 1'b0;
    stk_waddr  = depth[IW-1:0];
    stk_wdata  = {chk_addr, chk_col};
    stk_re     = 1'b0;
    stk_raddr  = depth_dec[IW-1:0];
    mod_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        mod_start = find_go;
        if (load_go) begin
          // a load rewrites the visited bit, which clears the map cell by cell
          cell_we    = 1'b1;
          cell_waddr = load_pos[IW-1:0];
          cell_wdata = {cell_char != EMPTY_CHAR, 1'b0};
        end
      end
      ST_SCAN_RD: begin
        cell_re    = !scan_end;
        cell_raddr = scan_pos[IW-1:0];
      end
      ST_SCAN_CHK: begin
        if (hit) begin
          cell_we    = 1'b1;
          cell_waddr = scan_idx;
          stk_we     = 1'b1;
          stk_waddr  = '0;
          stk_wdata  = {scan_idx, scan_idx_col};
        end
      end
      ST_POP: begin
        stk_re = (depth != '0);
      end
      ST_NBR: begin
        cell_re = n_ok;
        if (chk_ok && hit) begin
          cell_we = 1'b1;
          stk_we  = 1'b1;
        end
      end
      default: begin
        cell_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      grid_rows <= CFG_ROWS_RESET;
      grid_cols <= CFG_COLS_RESET;
      load_pos  <= '0;
      scan_pos  <= '0;
      scan_col  <= '0;
      depth     <= '0;
      found     <= '0;
      nb        <= '0;
      chk_ok    <= 1'b0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROWS: grid_rows <= cfg_data;
          REG_COLS: grid_cols <= cfg_data;
          default: ;
        endcase
      end
      if (load_go) begin
        load_pos <= load_pos + PW'(1);
        if (load_pos == '0) begin
          scan_pos <= '0;
          found    <= '0;
        end
      end
      case (state)
        ST_DIV: begin
          if (mod_done) begin
            scan_col <= mod_rem;
          end
        end
        ST_SCAN_RD: begin
          if (!scan_end) begin
            scan_idx     <= scan_pos[IW-1:0];
            scan_idx_col <= scan_col;
            scan_pos     <= scan_pos + PW'(1);
            scan_col     <= scan_col_inc;
          end
        end
        ST_SCAN_CHK: begin
          if (hit) begin
            depth <= PW'(1);
            area  <= '0;
          end
        end
        ST_POP: begin
          if (depth != '0) begin
            depth <= depth_dec;
          end
        end
        ST_POP_WAIT: begin
          cur_idx <= stk_rdata[SW-1:CW];
          cur_col <= stk_rdata[CW-1:0];
          area    <= area + AREA_W'(1);
          nb      <= NB_RIGHT;
          chk_ok  <= 1'b0;
        end
        ST_NBR: begin
          nb       <= nb + 3'd1;
          chk_ok   <= n_ok;
          chk_addr <= n_addr;
          chk_col  <= n_col;
          if (stk_we) begin
            depth <= depth + PW'(1);
          end
        end
        default: ;
      endcase
      done <= report_obj || report_none;
      if (report_obj) begin
        found         <= found + NUM_W'(1);
        object_number <= found + NUM_W'(1);
        object_area   <= area;
        none_left     <= 1'b0;
      end else if (report_none) begin
        object_number <= '0;
        object_area   <= '0;
        none_left     <= 1'b1;
      end
    end
  end

  goal_ram #(
    .DEPTH (CELL_COUNT),
    .WIDTH (2)
  ) u_cell_mem (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .re    (cell_re),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  goal_ram #(
    .DEPTH (CELL_COUNT),
    .WIDTH (SW)
  ) u_stack_mem (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  goal_mod_unit #(
    .DW (PW),
    .VW (CW)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (scan_pos),
    .divisor  (cols_used),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  `GOAL_ASSERT_SAME(a_none_is_empty, clk, rst, done && none_left, {object_number, object_area} == '0)
  `GOAL_ASSERT_SAME(a_push_has_room, clk, rst, stk_we, depth < PW'(CELL_COUNT))
  `GOAL_ASSERT_SAME(a_cell_rw_apart, clk, rst, cell_we && cell_re, cell_waddr != cell_raddr)
  `GOAL_ASSERT_NEXT(a_find_goes_busy, clk, rst, start && !busy && cmd == CMD_FIND, busy && !done)

endmodule

FILE: src/goal_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on goal_pkg for the default depth.
module goal_ram
  import goal_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_ROWS * DEF_MAX_COLS,
  parameter int WIDTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/goal_mod_unit.sv
// Bit-serial remainder unit: dividend modulo divisor, one bit per cycle.
// Depends on goal_pkg; used by the top level to find the scan column.
module goal_mod_unit
  import goal_pkg::*;
#(
  parameter int DW = 11,
  parameter int VW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [VW-1:0] rem
);

  localparam int CNT_W = $clog2(DW + 1);

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    dq;
  logic [VW:0]      shifted;

  assign shifted = {rem, dq[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
        dq  <= dividend;
        rem <= '0;
      end else if (run) begin
        dq  <= dq << 1;
        cnt <= cnt + CNT_W'(1);
        // remainder stays below the divisor, so VW bits hold it
        if (shifted >= {1'b0, divisor}) begin
          rem <= VW'(shifted - {1'b0, divisor});
        end else begin
          rem <= shifted[VW-1:0];
        end
        if (cnt == CNT_W'(DW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: tb/sv/grid_object_area_labeler_tb.sv
// Self-checking testbench for grid_object_area_labeler: loads grids, issues finds, and
// compares every area report with an in-bench flood-fill predictor or a scripted report.
// Depends on goal_pkg and the grid_object_area_labeler RTL.
`timescale 1ns / 100ps

module grid_object_area_labeler_tb;
  import goal_pkg::*;

  localparam int CELLS           = DEF_MAX_ROWS * DEF_MAX_COLS;
  localparam int RANDOM_REQUESTS = 700;
  localparam int SETTLE_CYCLES   = 16;
  localparam int CYCLE_LIMIT     = 400_000;
  localparam int REPORT_LIMIT    = 10;
  localparam int SCRIPT_LEN      = 22;

  // indexes past the register list; the block must ignore them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam logic [CHAR_W-1:0] CHAR_ONE = 8'd49;

  typedef struct packed {
    logic [NUM_W-1:0]  number;
    logic [AREA_W-1:0] area;
    logic              exhausted;
  } area_report_t;

  typedef enum logic [1:0] {ROW_SETTING, ROW_LOAD, ROW_FIND} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] index;
    logic [CHAR_W-1:0]    value;
    logic                 typed;
    area_report_t         report;
  } script_row_t;

  localparam area_report_t NO_REPORT = '0;
  localparam area_report_t SCAN_DONE = '{number: '0, area: '0, exhausted: 1'b1};

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic                 cmd;
  logic [CHAR_W-1:0]    cell_char;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 done;
  logic [NUM_W-1:0]     object_number;
  logic [AREA_W-1:0]    object_area;
  logic                 none_left;

  grid_object_area_labeler uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .cell_char    (cell_char),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .object_number(object_number),
    .object_area  (object_area),
    .none_left    (none_left)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // predictor state
  bit                cell_is_object [CELLS];
  bit                cell_visited   [CELLS];
  int unsigned       fill_stack     [CELLS];
  int unsigned       fill_depth;
  int unsigned       load_ptr;
  int unsigned       scan_ptr;
  logic [NUM_W-1:0]  objects_numbered;
  logic [CFG_W-1:0]  rows_setting;
  logic [CFG_W-1:0]  cols_setting;

  area_report_t pending_reports [$];
  area_report_t oldest_report;
  bit           last_find_exhausted;
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  script_row_t  script [SCRIPT_LEN];

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] raw, input int unsigned top);
    if (raw == 0) return 1;
    if (raw > top) return top;
    return raw;
  endfunction

  function automatic void mark_cell(input int unsigned idx);
    if (idx < CELLS && cell_is_object[idx] && !cell_visited[idx]) begin
      cell_visited[idx] = 1'b1;
      fill_stack[fill_depth] = idx;
      fill_depth++;
    end
  endfunction

  function automatic int unsigned flood_area(input int unsigned origin, input int unsigned cols,
                                             input int unsigned total);
    int unsigned area;
    int unsigned idx;
    area = 0;
    fill_depth = 0;
    mark_cell(origin);
    while (fill_depth > 0) begin
      fill_depth--;
      idx = fill_stack[fill_depth];
      area++;
      if (idx % cols + 1 < cols && idx + 1 < total) mark_cell(idx + 1);
      if (idx % cols > 0) mark_cell(idx - 1);
      if (idx + cols < total) mark_cell(idx + cols);
      if (idx >= cols) mark_cell(idx - cols);
    end
    return area;
  endfunction

  // Advance the predictor by one request; returns 1 when it yields an area report.
  function automatic bit next_report(input logic op, input logic [CHAR_W-1:0] ch,
                                     output area_report_t rep);
    int unsigned cols;
    int unsigned total;
    int unsigned idx;
    int unsigned area;
    cols  = clamp_dim(cols_setting, DEF_MAX_COLS);
    total = clamp_dim(rows_setting, DEF_MAX_ROWS) * cols;
    rep   = NO_REPORT;
    if (op == CMD_LOAD) begin
      if (load_ptr < total) begin
        if (load_ptr == 0) begin
          foreach (cell_visited[i]) cell_visited[i] = 1'b0;
          scan_ptr = 0;
          objects_numbered = '0;
        end
        cell_is_object[load_ptr] = (ch != EMPTY_CHAR);
        load_ptr++;
      end
      return 1'b0;
    end
    rep.exhausted = 1'b1;
    while (scan_ptr < total && rep.exhausted) begin
      idx = scan_ptr;
      scan_ptr++;
      if (cell_is_object[idx] && !cell_visited[idx]) begin
        area = flood_area(idx, cols, total);
        objects_numbered = objects_numbered + 1'b1;
        rep.number    = objects_numbered;
        rep.area      = area[AREA_W-1:0];
        rep.exhausted = 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char(input int unsigned density);
    logic [CHAR_W-1:0] ch;
    if ($urandom_range(0, 99) >= density) return EMPTY_CHAR;
    do ch = CHAR_W'($urandom_range(0, 255)); while (ch == EMPTY_CHAR);
    return ch;
  endfunction

  // Write a dimension, sometimes in an out-of-range form that clamps to the same size.
  function automatic logic [CFG_W-1:0] encode_dim(input int unsigned eff);
    if (eff == 1 && $urandom_range(0, 3) == 0) return '0;
    if (eff == 32 && $urandom_range(0, 2) == 0) return CFG_W'($urandom_range(33, 63));
    return CFG_W'(eff);
  endfunction

  task automatic pace(input bit quiet);
    int unsigned roll;
    int unsigned gap;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 70) gap = 0;
    else if (roll < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the request until accepted; start stays high for a back-to-back request.
  task automatic issue_request(input logic op, input logic [CHAR_W-1:0] ch, input bit typed,
                               input area_report_t typed_report);
    area_report_t predicted;
    start     <= 1'b1;
    cmd       <= op;
    cell_char <= ch;
    do @(posedge clk); while (busy !== 1'b0);
    if (next_report(op, ch, predicted)) begin
      pending_reports.push_back(typed ? typed_report : predicted);
      last_find_exhausted = predicted.exhausted;
    end
  endtask

  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == REG_ROWS) rows_setting = value;
    else if (idx == REG_COLS) cols_setting = value;
  endtask

  // Wait until every report is in and the block is idle, then let it settle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic note_mismatch(input string what, input area_report_t want);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t %s: expected number %0d area %0d none_left %0b, got %0d %0d %0b",
               $time, what, want.number, want.area, want.exhausted,
               object_number, object_area, none_left);
  endtask

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (pending_reports.size() == 0) begin
        note_mismatch("report with no find waiting", NO_REPORT);
      end else begin
        oldest_report = pending_reports.pop_front();
        if (object_number !== oldest_report.number || object_area !== oldest_report.area ||
            none_left !== oldest_report.exhausted)
          note_mismatch("wrong area report", oldest_report);
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("grid_object_area_labeler: mismatch");
    $finish;
  end

  initial begin
    int unsigned random_requests;
    int unsigned need;
    int unsigned span;
    int unsigned rows_eff;
    int unsigned cols_eff;
    int unsigned total;
    int unsigned density;
    bit          quiet;
    bit          first_phase;

    rst       = 1'b1;
    start     = 1'b0;
    cmd       = CMD_LOAD;
    cell_char = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ROWS;
    cfg_data  = '0;

    foreach (cell_is_object[i]) cell_is_object[i] = 1'b0;
    foreach (cell_visited[i]) cell_visited[i] = 1'b0;
    fill_depth       = 0;
    load_ptr         = 0;
    scan_ptr         = 0;
    objects_numbered = '0;
    rows_setting     = CFG_ROWS_RESET;
    cols_setting     = CFG_COLS_RESET;

    script = '{
      // one-row grid, rows written as zero: two single-cell objects, then an ignored load
      '{ROW_SETTING, REG_ROWS,    8'd0,       1'b0, NO_REPORT},
      '{ROW_SETTING, REG_COLS,    8'd3,       1'b0, NO_REPORT},
      '{ROW_LOAD,    REG_ROWS,    CHAR_ONE,   1'b0, NO_REPORT},
      '{ROW_LOAD,    REG_ROWS,    EMPTY_CHAR, 1'b0, NO_REPORT},
      '{ROW_LOAD,    REG_ROWS,    8'hFF,      1'b0, NO_REPORT},
      '{ROW_LOAD,    REG_ROWS,    EMPTY_CHAR, 1'b0, NO_REPORT},
      '{ROW_FIND,    REG_ROWS,    8'h00,      1'b1, '{number: 10'd1, area: 11'd1, exhausted: 1'b0}},
      '{ROW_FIND,    REG_ROWS,    8'hFF,      1'b1, '{number: 10'd2, area: 11'd1, exhausted: 1'b0}},
      '{ROW_FIND,    REG_ROWS,    8'h5A,      1'b1, SCAN_DONE},
      '{ROW_FIND,    REG_ROWS,    8'hA5,      1'b1, SCAN_DONE},
      // writes past the register list change nothing
      '{ROW_SETTING, REG_SPARE_A, 8'd63,      1'b0, NO_REPORT},
      '{ROW_SETTING, REG_SPARE_B, 8'd0,       1'b0, NO_REPORT},
      // grow to two rows after the scan ended: the scan resumes on the new cells
      '{ROW_SETTING, REG_ROWS,    8'd2,       1'b0, NO_REPORT},
      '{ROW_SETTING, REG_COLS,    8'd3,       1'b0, NO_REPORT},
      '{ROW_LOAD,    REG_ROWS,    8'h00,      1'b0, NO_REPORT},
      '{ROW_LOAD,    REG_ROWS,    CHAR_ONE,   1'b0, NO_REPORT},
      '{ROW_LOAD,    REG_ROWS,    EMPTY_CHAR, 1'b0, NO_REPORT},
      '{ROW_FIND,    REG_ROWS,    8'h00,      1'b0, NO_REPORT},
      '{ROW_FIND,    REG_ROWS,    8'h00,      1'b0, NO_REPORT},
      // reshape smaller than what was loaded: loads ignored, scan already past the end
      '{ROW_SETTING, REG_COLS,    8'd2,       1'b0, NO_REPORT},
      '{ROW_LOAD,    REG_ROWS,    8'hAA,      1'b0, NO_REPORT},
      '{ROW_FIND,    REG_ROWS,    8'h55,      1'b1, SCAN_DONE}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int row = 0; row < SCRIPT_LEN; row++) begin
      if (script[row].kind == ROW_SETTING) begin
        if (!cfg_valid) drain();
        write_setting(script[row].index, script[row].value[CFG_W-1:0]);
      end else begin
        if (cfg_valid) cfg_valid <= 1'b0;
        pace(1'b0);
        issue_request(script[row].kind == ROW_FIND ? CMD_FIND : CMD_LOAD, script[row].value,
                      script[row].typed, script[row].report);
      end
    end

    // Each phase: pick a shape, load any cells it adds, then find until the scan runs out.
    random_requests = 0;
    first_phase = 1'b1;
    while (random_requests < RANDOM_REQUESTS) begin
      drain();
      // keep the phase within what is left of the request budget
      span = RANDOM_REQUESTS - random_requests;
      if (span > 160) span = 160;
      if (span < 24) span = 24;
      need = load_ptr + $urandom_range(24, span);
      if (need > CELLS) need = CELLS;
      if (first_phase) cols_eff = 32;
      else begin
        case ($urandom_range(0, 7))
          0:       cols_eff = 1;
          1:       cols_eff = 32;
          default: cols_eff = $urandom_range(2, 31);
        endcase
      end
      if ($urandom_range(0, 4) == 0) rows_eff = $urandom_range(1, (need + cols_eff - 1) / cols_eff);
      else rows_eff = (need + cols_eff - 1) / cols_eff;
      if (rows_eff > 32) rows_eff = 32;
      if (rows_eff < 1) rows_eff = 1;
      total = rows_eff * cols_eff;

      write_setting(REG_ROWS, encode_dim(rows_eff));
      write_setting(REG_COLS, first_phase ? CFG_W'(63) : encode_dim(cols_eff));
      if ($urandom_range(0, 5) == 0)
        write_setting($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                      CFG_W'($urandom_range(0, 63)));
      cfg_valid <= 1'b0;
      first_phase = 1'b0;

      quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 4))
        0:       density = 10;
        1:       density = 35;
        2:       density = 55;
        3:       density = 80;
        default: density = 100;
      endcase

      while (load_ptr < total) begin
        pace(quiet);
        issue_request(CMD_LOAD, pick_char(density), 1'b0, NO_REPORT);
        random_requests++;
      end

      do begin
        // stray loads past the grid end are dropped by the block
        if ($urandom_range(0, 9) == 0) begin
          pace(quiet);
          issue_request(CMD_LOAD, CHAR_W'($urandom_range(0, 255)), 1'b0, NO_REPORT);
        end
        pace(quiet);
        issue_request(CMD_FIND, CHAR_W'($urandom_range(0, 255)), 1'b0, NO_REPORT);
        random_requests++;
      end while (!last_find_exhausted);

      repeat ($urandom_range(0, 2)) begin
        pace(quiet);
        issue_request(CMD_FIND, CHAR_W'($urandom_range(0, 255)), 1'b0, NO_REPORT);
        random_requests++;
      end
    end

    drain();
    if (mismatch_count == 0)
      $display("grid_object_area_labeler: match");
    else
      $display("grid_object_area_labeler: mismatch");
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/goal_pkg.sv
src/goal_ram.sv
src/goal_mod_unit.sv
src/grid_object_area_labeler.sv
tb/sv/grid_object_area_labeler_tb.sv
